@@ sv/dmn_pkg.sv @@
package dmn_pkg;

	// system size
	localparam int NUM_NODES = 10;
	localparam int SEQ_BITS  = 16;
	localparam int NODE_W    = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;

	// command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [SEQ_BITS-1:0] SEQ_MAX = '1;

	// event codes
	typedef enum logic [1:0] {
		OP_LOCAL_REQ = 2'd0,
		OP_PEER_REQ  = 2'd1,
		OP_PEER_REP  = 2'd2,
		OP_RELEASE   = 2'd3
	} op_e_t;

	// message codes
	typedef enum logic [1:0] {
		KIND_REQUEST = 2'd0,
		KIND_REPLY   = 2'd1,
		KIND_GRANT   = 2'd2
	} kind_e_t;

	// incoming event word
	typedef struct packed {
		logic [1:0]  req_type;
		logic [3:0]  peer_node;
		logic [15:0] peer_seq;
	} evt_t;

	// outgoing message word
	typedef struct packed {
		logic [1:0]  msg_kind;
		logic [3:0]  dest_node;
		logic [15:0] seq_value;
		logic        last;
	} msg_t;

	// classified command handed to the back end
	typedef struct packed {
		op_e_t               op;
		logic [3:0]          peer;
		logic [SEQ_BITS-1:0] pseq;
	} cmd_t;

	// queue status seen by the front end
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ sv/distributed_mutex_node_unit.sv @@
// One node of a Ricart-Agrawala mutual exclusion ring with held permissions.
// Events come in on evt (local request, peer REQUEST, peer REPLY, local
// release), messages and the entry grant go out on msg, last marking the
// final word of each event. A front end screens events into a two-entry
// command queue; a back-end sequencer owns the node state and emits at most
// one word per cycle into an output register. A peer REQUEST that gives back
// a held reply also re-sends a REQUEST from the tail state; a local request
// or release picks up the command and then walks the node list, one node per
// cycle while the output is not stalled, finishing on the highest node that
// gets a message. Write node_id through cfg only while the block is idle.
module distributed_mutex_node_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [3:0]    cfg_data,
	input  logic          evt_valid,
	output logic          evt_stall,
	input  dmn_pkg::evt_t evt,
	output logic          msg_valid,
	input  logic          msg_stall,
	output dmn_pkg::msg_t msg
);

	logic             [3:0] node_id_q;
	logic                   push;
	dmn_pkg::cmd_t          push_cmd;
	dmn_pkg::cmd_t          head;
	logic                   head_valid;
	logic                   pop;
	dmn_pkg::q_stat_t       q_stat;

	// node identity register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			node_id_q <= cfg_data;
		end
	end

	dmn_front u_front (
		.evt       (evt),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.node_id   (node_id_q),
		.q_stat    (q_stat),
		.push      (push),
		.cmd       (push_cmd)
	);

	dmn_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.q_stat     (q_stat)
	);

	dmn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.node_id   (node_id_q),
		.cmd       (head),
		.cmd_valid (head_valid),
		.cmd_pop   (pop),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg)
	);

endmodule

@@ sv/dmn_front.sv @@
module dmn_front (
	input  dmn_pkg::evt_t    evt,
	input  logic             evt_valid,
	output logic             evt_stall,
	input  logic [3:0]       node_id,
	input  dmn_pkg::q_stat_t q_stat,
	output logic             push,
	output dmn_pkg::cmd_t    cmd
);

	logic        is_peer;
	logic        peer_ok;
	logic [31:0] pseq_wide;

	// peer messages from self or from beyond the node range are dropped here
	always_comb begin
		is_peer   = evt.req_type inside {dmn_pkg::OP_PEER_REQ, dmn_pkg::OP_PEER_REP};
		peer_ok   = ({1'b0, evt.peer_node} < 5'(dmn_pkg::NUM_NODES)) &&
			(evt.peer_node != node_id);
		pseq_wide = 32'(evt.peer_seq);
	end

	// build the command, clamping the peer sequence to the local range
	always_comb begin
		cmd.op   = dmn_pkg::op_e_t'(evt.req_type);
		cmd.peer = evt.peer_node;
		cmd.pseq = (pseq_wide > 32'(dmn_pkg::SEQ_MAX)) ? dmn_pkg::SEQ_MAX :
			dmn_pkg::SEQ_BITS'(pseq_wide);
	end

	// accept whenever the queue has room; dropped events are simply consumed
	assign evt_stall = q_stat.full;
	assign push      = evt_valid && !q_stat.full && (!is_peer || peer_ok);

endmodule

@@ sv/dmn_cmd_queue.sv @@
module dmn_cmd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dmn_pkg::cmd_t    push_cmd,
	input  logic             pop,
	output dmn_pkg::cmd_t    head,
	output logic             head_valid,
	output dmn_pkg::q_stat_t q_stat
);

	dmn_pkg::cmd_t                 entry_q [dmn_pkg::QDEPTH];
	logic [dmn_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [dmn_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [dmn_pkg::QCNT_W-1:0]   count_q;
	logic                          do_push;
	logic                          do_pop;

	always_comb begin
		q_stat.full  = (count_q == dmn_pkg::QCNT_W'(dmn_pkg::QDEPTH));
		q_stat.empty = (count_q == '0);
		head_valid   = !q_stat.empty;
		head         = entry_q[rd_ptr_q];
		do_push      = push && !q_stat.full;
		do_pop       = pop && !q_stat.empty;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == dmn_pkg::QPTR_W'(dmn_pkg::QDEPTH - 1)) ? '0 :
					wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == dmn_pkg::QPTR_W'(dmn_pkg::QDEPTH - 1)) ? '0 :
					rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// payload storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ sv/dmn_back.sv @@
module dmn_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [3:0]    node_id,
	input  dmn_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_pop,
	output logic          msg_valid,
	input  logic          msg_stall,
	output dmn_pkg::msg_t msg
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_TAIL = 3'b100
	} state_t;

	localparam int N  = dmn_pkg::NUM_NODES;
	localparam int SB = dmn_pkg::SEQ_BITS;

	state_t                   state_q, state_d;
	logic                     in_sec_q, in_sec_d;
	logic                     wait_q, wait_d;
	logic [SB-1:0]            own_seq_q, own_seq_d;
	logic [SB-1:0]            high_seq_q, high_seq_d;
	logic [N-1:0]             held_q, held_d;
	logic [N-1:0]             defer_q, defer_d;
	logic [N-1:0]             scan_q, scan_d;
	logic [dmn_pkg::NODE_W-1:0] idx_q, idx_d;
	dmn_pkg::kind_e_t         scan_kind_q, scan_kind_d;
	logic [3:0]               peer_q, peer_d;
	logic                     msg_valid_q;
	dmn_pkg::msg_t            msg_q;

	logic                     can_emit;
	logic                     emit;
	dmn_pkg::msg_t            emit_word;
	logic [N-1:0]             self_mask;
	logic [N-1:0]             peer_bit;
	logic [N-1:0]             idx_bit;
	logic [N-1:0]             work_mask;
	logic [N-1:0]             rest;
	logic [SB-1:0]            seq_inc;
	logic                     mine;
	logic                     had;

	// per-node decode of own id, peer and scan position
	always_comb begin
		for (int i = 0; i < N; i++) begin
			self_mask[i] = (node_id == 4'(i));
			peer_bit[i]  = (cmd.peer == 4'(i));
			idx_bit[i]   = (idx_q == dmn_pkg::NODE_W'(i));
		end
		seq_inc  = (high_seq_q == dmn_pkg::SEQ_MAX) ? dmn_pkg::SEQ_MAX : high_seq_q + 1'b1;
		mine     = (cmd.pseq > own_seq_q) || ((cmd.pseq == own_seq_q) && (cmd.peer > node_id));
		had      = |(held_q & peer_bit);
		can_emit = !msg_valid_q || !msg_stall;
		rest     = scan_q & ~idx_bit;
	end

	// sequencer: one command at a time, at most one word per cycle
	always_comb begin
		state_d     = state_q;
		in_sec_d    = in_sec_q;
		wait_d      = wait_q;
		own_seq_d   = own_seq_q;
		high_seq_d  = high_seq_q;
		held_d      = held_q;
		defer_d     = defer_q;
		scan_d      = scan_q;
		idx_d       = idx_q;
		scan_kind_d = scan_kind_q;
		peer_d      = peer_q;
		cmd_pop     = 1'b0;
		emit        = 1'b0;
		emit_word   = '0;
		work_mask   = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && can_emit) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						dmn_pkg::OP_LOCAL_REQ: begin
							if (!in_sec_q && !wait_q) begin
								own_seq_d = seq_inc;
								work_mask = ~held_q & ~self_mask;
								if (work_mask == '0) begin
									in_sec_d           = 1'b1;
									emit               = 1'b1;
									emit_word.msg_kind = dmn_pkg::KIND_GRANT;
									emit_word.last     = 1'b1;
								end else begin
									wait_d      = 1'b1;
									scan_d      = work_mask;
									idx_d       = '0;
									scan_kind_d = dmn_pkg::KIND_REQUEST;
									state_d     = ST_SCAN;
								end
							end
						end
						dmn_pkg::OP_PEER_REQ: begin
							if (cmd.pseq > high_seq_q) begin
								high_seq_d = cmd.pseq;
							end
							if (in_sec_q || (wait_q && mine)) begin
								defer_d = defer_q | peer_bit;
							end else begin
								held_d              = held_q & ~peer_bit;
								emit                = 1'b1;
								emit_word.msg_kind  = dmn_pkg::KIND_REPLY;
								emit_word.dest_node = cmd.peer;
								emit_word.last      = !(wait_q && had);
								if (wait_q && had) begin
									peer_d  = cmd.peer;
									state_d = ST_TAIL;
								end
							end
						end
						dmn_pkg::OP_PEER_REP: begin
							held_d = held_q | peer_bit;
							if (wait_q && (&(held_d | self_mask))) begin
								in_sec_d           = 1'b1;
								wait_d             = 1'b0;
								emit               = 1'b1;
								emit_word.msg_kind = dmn_pkg::KIND_GRANT;
								emit_word.last     = 1'b1;
							end
						end
						dmn_pkg::OP_RELEASE: begin
							if (in_sec_q) begin
								in_sec_d  = 1'b0;
								work_mask = defer_q & ~self_mask;
								defer_d   = '0;
								held_d    = held_q & ~work_mask;
								if (work_mask != '0) begin
									scan_d      = work_mask;
									idx_d       = '0;
									scan_kind_d = dmn_pkg::KIND_REPLY;
									state_d     = ST_SCAN;
								end
							end
						end
						default: begin
							cmd_pop = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				// walk the node list, one node per cycle while the output is not stalled
				if (can_emit) begin
					if (|(scan_q & idx_bit)) begin
						emit                = 1'b1;
						emit_word.msg_kind  = scan_kind_q;
						emit_word.dest_node = 4'(idx_q);
						emit_word.seq_value = (scan_kind_q == dmn_pkg::KIND_REQUEST) ?
							16'(own_seq_q) : '0;
						emit_word.last      = (rest == '0);
					end
					scan_d = rest;
					idx_d  = dmn_pkg::NODE_W'(idx_q + 1'b1);
					if (rest == '0) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_TAIL: begin
				// re-request after giving back a held reply
				if (can_emit) begin
					emit                = 1'b1;
					emit_word.msg_kind  = dmn_pkg::KIND_REQUEST;
					emit_word.dest_node = peer_q;
					emit_word.seq_value = 16'(own_seq_q);
					emit_word.last      = 1'b1;
					state_d             = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_sec_q    <= 1'b0;
			wait_q      <= 1'b0;
			own_seq_q   <= '0;
			high_seq_q  <= '0;
			held_q      <= '0;
			defer_q     <= '0;
			scan_q      <= '0;
			idx_q       <= '0;
			msg_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			in_sec_q   <= in_sec_d;
			wait_q     <= wait_d;
			own_seq_q  <= own_seq_d;
			high_seq_q <= high_seq_d;
			held_q     <= held_d;
			defer_q    <= defer_d;
			scan_q     <= scan_d;
			idx_q      <= idx_d;
			if (emit) begin
				msg_valid_q <= 1'b1;
			end else if (!msg_stall) begin
				msg_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		scan_kind_q <= scan_kind_d;
		peer_q      <= peer_d;
		if (emit) begin
			msg_q <= emit_word;
		end
	end

	assign msg_valid = msg_valid_q;
	assign msg       = msg_q;

endmodule

@@ sv/dmn_checker.sv @@
module dmn_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          msg_valid,
	input logic          msg_stall,
	input dmn_pkg::msg_t msg
);

	// a stalled word stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_stall |=> msg_valid && $stable(msg))
		else $error("stalled message word changed");

	// a grant is a lone final word with no destination or sequence
	assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && (msg.msg_kind == dmn_pkg::KIND_GRANT) |->
		msg.last && (msg.dest_node == '0) && (msg.seq_value == '0))
		else $error("malformed grant");

	// replies carry no sequence number
	assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && (msg.msg_kind == dmn_pkg::KIND_REPLY) |-> (msg.seq_value == '0))
		else $error("reply with sequence number");

	// messages only go to nodes in range
	assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && (msg.msg_kind != dmn_pkg::KIND_GRANT) |->
		({1'b0, msg.dest_node} < 5'(dmn_pkg::NUM_NODES)))
		else $error("message to node out of range");

endmodule

bind distributed_mutex_node_unit dmn_checker u_chk (.*);
